// ===== sv/sha1bh_pkg.sv =====
// Package for the SHA-1 block hash: word types, state and round-group codes,
// the initial chaining value and the round constants.
// No dependencies.
`default_nettype none

package sha1bh_pkg;

    typedef logic [31:0] word_t;
    typedef word_t [4:0] words5_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        GRP_CH,
        GRP_PARITY_LO,
        GRP_MAJ,
        GRP_PARITY_HI
    } round_grp_t;

    typedef struct packed {
        logic       load;
        logic       step;
        round_grp_t grp;
    } round_ctrl_t;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned WORD_POS_W  = $clog2(BLOCK_WORDS);
    localparam int unsigned ROUND_CNT_W = $clog2(ROUNDS);

    localparam words5_t INIT_VALUE = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam word_t K_GRP0 = 32'h5A827999;
    localparam word_t K_GRP1 = 32'h6ED9EBA1;
    localparam word_t K_GRP2 = 32'h8F1BBCDC;
    localparam word_t K_GRP3 = 32'hCA62C1D6;

endpackage

`default_nettype wire

// ===== sv/sha1_block_hash.sv =====
// SHA-1 block hash over an already padded message: each block of sixteen
// 32-bit words is taken in sixteen transfers, then compressed by one shared
// round unit over the 80 rounds and a final step that adds the result into
// the chaining words; input is stalled during the compression. The flags
// are taken from the sixteenth word of each block. After a last block the
// digest is held in an output register until transferred; the finishing
// step waits only if the previous digest has not yet left.
// Depends on sha1bh_pkg, sha1bh_schedule, sha1bh_round, sha1bh_out_stage.
`default_nettype none

module sha1_block_hash (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire sha1bh_pkg::word_t  message_word,
    input  wire logic               first_block,
    input  wire logic               last_block,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output sha1bh_pkg::word_t       digest_a,
    output sha1bh_pkg::word_t       digest_b,
    output sha1bh_pkg::word_t       digest_c,
    output sha1bh_pkg::word_t       digest_d,
    output sha1bh_pkg::word_t       digest_e
);
    import sha1bh_pkg::*;

    state_t                 state_reg, state_next;
    logic [WORD_POS_W-1:0]  word_pos_reg, word_pos_next;
    logic [ROUND_CNT_W-1:0] round_cnt_reg, round_cnt_next;
    logic                   last_reg, last_next;
    words5_t                chain_reg, chain_next;
    words5_t                chain_sum;
    words5_t                round_load_value;
    words5_t                work;
    words5_t                digest;
    word_t                  w_word;
    round_ctrl_t            round_ctrl;
    logic                   in_xfer;
    logic                   block_full;
    logic                   out_push;
    logic                   out_can_push;

    sha1bh_schedule u_schedule (
        .clk       (clk),
        .load_en   (in_xfer),
        .load_word (message_word),
        .expand_en (round_ctrl.step),
        .w_out     (w_word)
    );

    sha1bh_round u_round (
        .clk        (clk),
        .ctrl       (round_ctrl),
        .load_value (round_load_value),
        .w_in       (w_word),
        .work       (work)
    );

    sha1bh_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (out_push),
        .push_value (chain_sum),
        .stall      (out_stall),
        .valid      (out_valid),
        .can_push   (out_can_push),
        .value      (digest)
    );

    always_comb
    begin
        in_stall = (state_reg != ST_LOAD);
        in_xfer = in_valid && !in_stall;
        block_full = in_xfer && (word_pos_reg == WORD_POS_W'(BLOCK_WORDS - 1));

        for (int i = 0; i < 5; i++)
        begin
            chain_sum[i] = chain_reg[i] + work[i];
        end
        round_load_value = first_block ? INIT_VALUE : chain_reg;

        if (round_cnt_reg < ROUND_CNT_W'(20))
        begin
            round_ctrl.grp = GRP_CH;
        end
        else if (round_cnt_reg < ROUND_CNT_W'(40))
        begin
            round_ctrl.grp = GRP_PARITY_LO;
        end
        else if (round_cnt_reg < ROUND_CNT_W'(60))
        begin
            round_ctrl.grp = GRP_MAJ;
        end
        else
        begin
            round_ctrl.grp = GRP_PARITY_HI;
        end
        round_ctrl.load = block_full;
        round_ctrl.step = (state_reg == ST_ROUND);

        state_next = state_reg;
        word_pos_next = word_pos_reg;
        round_cnt_next = round_cnt_reg;
        last_next = last_reg;
        chain_next = chain_reg;
        out_push = 1'b0;

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    word_pos_next = word_pos_reg + WORD_POS_W'(1);
                end
                if (block_full)
                begin
                    last_next = last_block;
                    chain_next = round_load_value;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (round_cnt_reg == ROUND_CNT_W'(ROUNDS - 1))
                begin
                    round_cnt_next = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    round_cnt_next = round_cnt_reg + ROUND_CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                if (!last_reg || out_can_push)
                begin
                    out_push = last_reg;
                    chain_next = chain_sum;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        digest_a = digest[0];
        digest_b = digest[1];
        digest_c = digest[2];
        digest_d = digest[3];
        digest_e = digest[4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            word_pos_reg <= '0;
            round_cnt_reg <= '0;
            last_reg <= 1'b0;
            chain_reg <= INIT_VALUE;
        end
        else
        begin
            state_reg <= state_next;
            word_pos_reg <= word_pos_next;
            round_cnt_reg <= round_cnt_next;
            last_reg <= last_next;
            chain_reg <= chain_next;
        end
    end

    a_new_digest_after_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH) && $past(last_reg)
    ) else $error("digest appeared without a finished last block");

    a_round_count_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        round_cnt_reg <= ROUND_CNT_W'(ROUNDS - 1)
    ) else $error("round counter out of range");

    a_word_pos_clear_outside_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (word_pos_reg == '0) && (round_cnt_reg == '0 ||
            state_reg == ST_ROUND)
    ) else $error("counters not idle outside their phase");

endmodule

`default_nettype wire

// ===== sv/sha1bh_schedule.sv =====
// Message schedule of the SHA-1 block hash: a 16-word shift line that takes
// the block words and then produces the expanded words, one per round.
// Depends on sha1bh_pkg.
`default_nettype none

module sha1bh_schedule (
    input  wire logic           clk,
    input  wire logic           load_en,
    input  wire sha1bh_pkg::word_t load_word,
    input  wire logic           expand_en,
    output sha1bh_pkg::word_t   w_out
);
    import sha1bh_pkg::*;

    word_t ring_reg [BLOCK_WORDS];
    word_t mix;
    word_t shift_in;

    // The oldest entry is the word used in the current round.
    always_comb
    begin
        mix = ring_reg[BLOCK_WORDS-1] ^ ring_reg[BLOCK_WORDS-3]
            ^ ring_reg[BLOCK_WORDS-9] ^ ring_reg[BLOCK_WORDS-14];
        shift_in = load_en ? load_word : {mix[30:0], mix[31]};
        w_out = ring_reg[BLOCK_WORDS-1];
    end

    always_ff @(posedge clk)
    begin
        if (load_en || expand_en)
        begin
            ring_reg[0] <= shift_in;
            for (int i = 1; i < BLOCK_WORDS; i++)
            begin
                ring_reg[i] <= ring_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/sha1bh_round.sv =====
// Round unit of the SHA-1 block hash: the five working words and the shared
// round logic that advances them by one round per step.
// Depends on sha1bh_pkg.
`default_nettype none

module sha1bh_round (
    input  wire logic                    clk,
    input  wire sha1bh_pkg::round_ctrl_t ctrl,
    input  wire sha1bh_pkg::words5_t     load_value,
    input  wire sha1bh_pkg::word_t       w_in,
    output sha1bh_pkg::words5_t          work
);
    import sha1bh_pkg::*;

    words5_t work_reg;
    words5_t work_next;
    word_t   a, b, c, d, e;
    word_t   f;
    word_t   k;

    always_comb
    begin
        a = work_reg[0];
        b = work_reg[1];
        c = work_reg[2];
        d = work_reg[3];
        e = work_reg[4];
        case (ctrl.grp)
            GRP_CH:
            begin
                f = (b & c) | (~b & d);
                k = K_GRP0;
            end
            GRP_PARITY_LO:
            begin
                f = b ^ c ^ d;
                k = K_GRP1;
            end
            GRP_MAJ:
            begin
                f = (b & c) | (b & d) | (c & d);
                k = K_GRP2;
            end
            default:
            begin
                f = b ^ c ^ d;
                k = K_GRP3;
            end
        endcase
        work_next[0] = {a[26:0], a[31:27]} + f + e + k + w_in;
        work_next[1] = a;
        work_next[2] = {b[1:0], b[31:2]};
        work_next[3] = c;
        work_next[4] = d;
        work = work_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            work_reg <= load_value;
        end
        else if (ctrl.step)
        begin
            work_reg <= work_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/sha1bh_top_placeholder.sv =====
// Digest output stage of the SHA-1 block hash: holds one digest until the
// output transfer completes, so the next block can load meanwhile.
// Depends on sha1bh_pkg.
`default_nettype none

module sha1bh_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire sha1bh_pkg::words5_t push_value,
    input  wire logic                stall,
    output logic                     valid,
    output logic                     can_push,
    output sha1bh_pkg::words5_t      value
);
    import sha1bh_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    words5_t value_reg;

    always_comb
    begin
        can_push = !valid_reg || !stall;
        valid_next = valid_reg && stall;
        if (push && can_push)
        begin
            valid_next = 1'b1;
        end
        valid = valid_reg;
        value = value_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && can_push)
        begin
            value_reg <= push_value;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sha1_digest_checker.sv =====
// Digest checker for sha1_block_hash: watches both channels, predicts each digest
// from the accepted message words, and compares every output transfer with it.
// Depends on sha1bh_pkg for word types, the initial value and round constants.
module sha1_digest_checker (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire sha1bh_pkg::word_t message_word,
    input  wire logic              first_block,
    input  wire logic              last_block,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire sha1bh_pkg::word_t digest_a,
    input  wire sha1bh_pkg::word_t digest_b,
    input  wire sha1bh_pkg::word_t digest_c,
    input  wire sha1bh_pkg::word_t digest_d,
    input  wire sha1bh_pkg::word_t digest_e,
    output int                     fail_count,
    output int                     outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import sha1bh_pkg::*;

    words5_t     chain_value;
    word_t       block_words [16];
    int unsigned word_count;
    words5_t     expected_digests [$];

    function automatic word_t rotl(input word_t x, input int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic words5_t sha1_compress(input words5_t chain, input word_t blk [16]);
        word_t      w [80];
        word_t      a, b, c, d, e, f, k, t;
        round_grp_t grp;
        words5_t    next;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int i = 0; i < 80; i++)
        begin
            if (i < 16)
                w[i] = blk[i];
            else
                w[i] = rotl(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
            grp = round_grp_t'(i / 20);
            case (grp)
                GRP_CH:
                begin
                    f = (b & c) | (~b & d);
                    k = K_GRP0;
                end
                GRP_PARITY_LO:
                begin
                    f = b ^ c ^ d;
                    k = K_GRP1;
                end
                GRP_MAJ:
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_GRP2;
                end
                default:
                begin
                    f = b ^ c ^ d;
                    k = K_GRP3;
                end
            endcase
            t = rotl(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        next[0] = chain[0] + a;
        next[1] = chain[1] + b;
        next[2] = chain[2] + c;
        next[3] = chain[3] + d;
        next[4] = chain[4] + e;
        return next;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        words5_t got;
        words5_t want;
        string   field_names [5];
        field_names = '{"digest_a", "digest_b", "digest_c", "digest_d", "digest_e"};
        if (!rst_n)
        begin
            chain_value = INIT_VALUE;
            word_count  = 0;
            expected_digests.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got = {digest_e, digest_d, digest_c, digest_b, digest_a};
                if (expected_digests.size() == 0)
                begin
                    $error("digest transfer with no digest expected: %08h %08h %08h %08h %08h",
                           digest_a, digest_b, digest_c, digest_d, digest_e);
                    fail_count++;
                end
                else
                begin
                    want = expected_digests.pop_front();
                    for (int i = 0; i < 5; i++)
                    begin
                        if (got[i] !== want[i])
                        begin
                            $error("%s mismatch: expected %08h, actual %08h",
                                   field_names[i], want[i], got[i]);
                            fail_count++;
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                block_words[word_count] = message_word;
                if (word_count == 15)
                begin
                    word_count = 0;
                    if (first_block)
                        chain_value = INIT_VALUE;
                    chain_value = sha1_compress(chain_value, block_words);
                    if (last_block)
                        expected_digests.insert(expected_digests.size(), chain_value);
                end
                else
                    word_count++;
            end
            outstanding = expected_digests.size();
        end
    end

endmodule

// ===== tb/tb_sha1_block_hash.sv =====
// Top of the sha1_block_hash testbench: clock, reset, message stimulus with idle
// and stall phases, and the verdict. Needs sha1bh_pkg, the block and
// sha1_digest_checker, which does all prediction and comparison.
module tb_sha1_block_hash;
    timeunit 1ns;
    timeprecision 1ps;

    import sha1bh_pkg::*;

    localparam int SEND_IDLE_PCT [4] = '{0, 69, 0, 21};
    localparam int STALL_PCT [4]     = '{0, 0, 69, 21};
    localparam int HOLD_CYCLES       = 600;
    localparam int DIRECTED_WORDS    = 32;
    localparam int WORDS_PER_PHASE   = 256;
    localparam int DRAIN_CYCLES      = 200;

    logic  clk          = 1'b0;
    logic  rst_n        = 1'b0;
    logic  in_valid     = 1'b0;
    logic  in_stall;
    word_t message_word = '0;
    logic  first_block  = 1'b0;
    logic  last_block   = 1'b0;
    logic  out_valid;
    logic  out_stall    = 1'b0;
    word_t digest_a, digest_b, digest_c, digest_d, digest_e;

    int    fail_count;
    int    outstanding;
    int    send_idle_pct  = 0;
    int    stall_pct      = 0;
    bit    hold_request   = 1'b0;
    int    words_sent     = 0;

    sha1_block_hash i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_word (message_word),
        .first_block  (first_block),
        .last_block   (last_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_a     (digest_a),
        .digest_b     (digest_b),
        .digest_c     (digest_c),
        .digest_d     (digest_d),
        .digest_e     (digest_e)
    );

    sha1_digest_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_word (message_word),
        .first_block  (first_block),
        .last_block   (last_block),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_a     (digest_a),
        .digest_b     (digest_b),
        .digest_c     (digest_c),
        .digest_d     (digest_d),
        .digest_e     (digest_e),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic word_t random_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input word_t value, input logic first, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        message_word <= value;
        first_block  <= first;
        last_block   <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Flags on the first fifteen words of a block are ignored, so they are random.
    task automatic send_block(input word_t words [16], input logic first, input logic last);
        for (int i = 0; i < 15; i++)
            send_word(words[i], 1'($urandom_range(1)), 1'($urandom_range(1)));
        send_word(words[15], first, last);
    endtask

    task automatic send_message();
        int unsigned blocks;
        bit          broken;
        logic        first;
        logic        last;
        word_t       words [16];
        blocks = $urandom_range(1, 3);
        broken = ($urandom_range(99) < 15);
        for (int b = 0; b < blocks; b++)
        begin
            first = (b == 0);
            last  = (b == blocks - 1);
            if (broken)
            begin
                first = 1'($urandom_range(1));
                last  = 1'($urandom_range(1));
            end
            foreach (words[i])
                words[i] = random_word();
            send_block(words, first, last);
        end
    endtask

    task automatic wait_for_digests();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
    endtask

    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    initial
    begin
        word_t extreme_block [16];
        word_t abc_block [16];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (extreme_block[i])
            extreme_block[i] = i[0] ? '1 : '0;
        foreach (abc_block[i])
            abc_block[i] = '0;
        abc_block[0]  = 32'h61626380;
        abc_block[15] = 32'h00000018;

        // Straight after reset, a block with no first flag chains from the initial value.
        send_block(extreme_block, 1'b0, 1'b1);
        send_block(abc_block, 1'b1, 1'b1);
        wait_for_digests();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            stall_pct     = STALL_PCT[ph];
            if (ph == 0)
                hold_request = 1'b1;
            while (words_sent < DIRECTED_WORDS + (ph + 1) * WORDS_PER_PHASE)
            begin
                send_message();
                if ($urandom_range(15) == 0)
                    wait_for_digests();
            end
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule
